// ===== hw/rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, constants and counter update functions of the tournament
// branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int HIST_BITS  = 7;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [1:0] MODE_TAKEN   = 2'd0;
  localparam logic [1:0] MODE_LOCAL   = 2'd1;
  localparam logic [1:0] MODE_GSHARE  = 2'd2;
  localparam logic [1:0] MODE_TOURNEY = 2'd3;

  localparam logic [1:0] CTR_INIT = 2'd3;

  typedef logic [1:0] ctr_t;

  typedef struct packed {
    logic was_correct;
    logic chose_global;
    logic global_guess;
    logic local_guess;
    logic predict_taken;
  } result_t;

  function automatic ctr_t sat_train(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == 2'd3) ? c : c + 2'd1;
    end else begin
      r = (c == 2'd0) ? c : c - 2'd1;
    end
    return r;
  endfunction

  function automatic ctr_t chooser_next(input ctr_t c, input logic tour, input logic lg,
                                        input logic gg, input logic dir);
    ctr_t r;
    r = c;
    if (tour == dir) begin
      if (c == 2'd2) begin
        r = 2'd3;
      end else if (c == 2'd1) begin
        r = 2'd0;
      end
    end else if (c[1]) begin
      if (lg == dir) begin
        r = c - 2'd1;
      end
    end else if (gg == dir) begin
      r = c + 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tbp_ram.sv =====
// ----------------------------------------------------------------------------
// tbp_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter int ADDR_W = 10,
  parameter int WIDTH  = 2
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tbp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// tbp_out_fifo
// Small result queue between the predictor pipeline and the output stream.
// ----------------------------------------------------------------------------
module tbp_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  tbp_pkg::result_t               push_data,
  output logic                           m_valid,
  input  logic                           m_ready,
  output tbp_pkg::result_t               m_data,
  output logic [tbp_pkg::FIFO_CNT_W-1:0] count
);

  tbp_pkg::result_t                mem [tbp_pkg::FIFO_DEPTH];
  logic [tbp_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [tbp_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic                            pop;

  assign m_valid = (count != '0);
  assign m_data  = mem[rd_ptr];
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{(tbp_pkg::FIFO_CNT_W-1){1'b0}}, push}
                     - {{(tbp_pkg::FIFO_CNT_W-1){1'b0}}, pop};
    end
  end

endmodule

// ===== hw/rtl/tournament_branch_predictor_core.sv =====
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core
// Local-history plus gshare branch predictor with a chooser table; predicts,
// then trains on each branch.
//
//   channel  dir  handshake                    payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  tdata: branch_address, taken
//   m_axis   out  m_axis_tvalid/m_axis_tready  tdata: result bits
//   cfg      in   cfg_wr_en                    cfg_wr_data: predictor_mode
//
// One branch per cycle while s_axis_tready is high; each result is pushed
// into the result queue from stage 2. Local history RAM is read on transfer,
// counter RAMs in the next cycle, written back in the cycle after that;
// same-entry overlaps are forwarded. After reset a clearing pass that writes
// every history and counter entry holds s_axis_tready low.
// A four-entry result queue with credit control absorbs m_axis stalls.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core #(
  parameter int LOG_ENTRIES = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] branch_address, [32] taken
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] predict_taken, [1] local_guess,
                                      // [2] global_guess, [3] chose_global,
                                      // [4] was_correct
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  localparam int LE  = LOG_ENTRIES;
  localparam int HB  = tbp_pkg::HIST_BITS;
  localparam int CLR = (LE > HB) ? LE : HB;

  logic [1:0]    mode;
  logic          clearing;
  logic [CLR-1:0] clr_addr;
  logic [LE-1:0] ghist;
  logic [LE:0]   ghist_ext;

  logic          in_fire;
  logic [HB-1:0] in_hsel;
  logic [LE-1:0] in_cidx;

  logic          s1_valid;
  logic          s1_dir;
  logic [HB-1:0] s1_hsel;
  logic [LE-1:0] s1_gidx;
  logic [LE-1:0] s1_cidx;
  logic          s1_hfwd;
  logic [LE-1:0] s1_hfwd_val;
  logic [LE-1:0] hram_q;
  logic [LE-1:0] hist_cur;
  logic [LE:0]   hist_ext;
  logic [LE-1:0] hist_new;

  logic          s2_valid;
  logic          s2_dir;
  logic [LE-1:0] s2_lidx;
  logic [LE-1:0] s2_gidx;
  logic [LE-1:0] s2_cidx;
  logic          s2_lfwd;
  logic          s2_gfwd;
  logic          s2_cfwd;
  tbp_pkg::ctr_t s2_lfwd_val;
  tbp_pkg::ctr_t s2_gfwd_val;
  tbp_pkg::ctr_t s2_cfwd_val;
  tbp_pkg::ctr_t lram_q;
  tbp_pkg::ctr_t gram_q;
  tbp_pkg::ctr_t cram_q;
  tbp_pkg::ctr_t l_ctr;
  tbp_pkg::ctr_t g_ctr;
  tbp_pkg::ctr_t c_ctr;
  tbp_pkg::ctr_t l_new;
  tbp_pkg::ctr_t g_new;
  tbp_pkg::ctr_t c_new;
  logic          tour;
  logic          pred;
  tbp_pkg::result_t res;

  logic                           hram_we;
  logic [HB-1:0]                  hram_waddr;
  logic [LE-1:0]                  hram_wdata;
  logic                           cram_we;
  logic [LE-1:0]                  lram_waddr;
  logic [LE-1:0]                  gram_waddr;
  logic [LE-1:0]                  cram_waddr;
  tbp_pkg::ctr_t                  lram_wdata;
  tbp_pkg::ctr_t                  gram_wdata;
  tbp_pkg::ctr_t                  cram_wdata;
  logic [tbp_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [3:0]                     inflight;
  tbp_pkg::result_t               out_res;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_hsel   = s_axis_tdata[HB-1:0];
  assign in_cidx   = s_axis_tdata[LE-1:0];
  assign ghist_ext = {ghist, s_axis_tdata[32]};

  assign inflight = 4'(fifo_count) + {3'b0, s1_valid} + {3'b0, s2_valid};
  assign s_axis_tready = !clearing && (inflight < 4'(tbp_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= tbp_pkg::MODE_TOURNEY;
      clearing <= 1'b1;
      clr_addr <= '0;
      ghist    <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        clearing <= !(&clr_addr);
      end
      if (in_fire) begin
        ghist <= ghist_ext[LE-1:0];
      end
      s1_valid <= in_fire;
      s2_valid <= s1_valid;
    end
  end

  // stage 1: history lookup, history update, counter read issue
  always_ff @(posedge clk) begin
    s1_dir      <= s_axis_tdata[32];
    s1_hsel     <= in_hsel;
    s1_gidx     <= in_cidx ^ ghist;
    s1_cidx     <= in_cidx;
    s1_hfwd     <= s1_valid && (s1_hsel == in_hsel);
    s1_hfwd_val <= hist_new;
  end

  assign hist_cur = s1_hfwd ? s1_hfwd_val : hram_q;
  assign hist_ext = {hist_cur, s1_dir};
  assign hist_new = hist_ext[LE-1:0];

  // stage 2: counter evaluation and write-back
  always_ff @(posedge clk) begin
    s2_dir      <= s1_dir;
    s2_lidx     <= hist_cur;
    s2_gidx     <= s1_gidx;
    s2_cidx     <= s1_cidx;
    s2_lfwd     <= s2_valid && (s2_lidx == hist_cur);
    s2_gfwd     <= s2_valid && (s2_gidx == s1_gidx);
    s2_cfwd     <= s2_valid && (s2_cidx == s1_cidx);
    s2_lfwd_val <= l_new;
    s2_gfwd_val <= g_new;
    s2_cfwd_val <= c_new;
  end

  assign l_ctr = s2_lfwd ? s2_lfwd_val : lram_q;
  assign g_ctr = s2_gfwd ? s2_gfwd_val : gram_q;
  assign c_ctr = s2_cfwd ? s2_cfwd_val : cram_q;
  assign tour  = c_ctr[1] ? g_ctr[1] : l_ctr[1];

  always_comb begin
    case (mode)
      tbp_pkg::MODE_TAKEN:  pred = 1'b1;
      tbp_pkg::MODE_LOCAL:  pred = l_ctr[1];
      tbp_pkg::MODE_GSHARE: pred = g_ctr[1];
      default:              pred = tour;
    endcase
  end

  assign l_new = tbp_pkg::sat_train(l_ctr, s2_dir);
  assign g_new = tbp_pkg::sat_train(g_ctr, s2_dir);
  assign c_new = tbp_pkg::chooser_next(c_ctr, tour, l_ctr[1], g_ctr[1], s2_dir);

  assign res.predict_taken = pred;
  assign res.local_guess   = l_ctr[1];
  assign res.global_guess  = g_ctr[1];
  assign res.chose_global  = c_ctr[1];
  assign res.was_correct   = (pred == s2_dir);

  // write ports: clearing pass, otherwise pipeline write-back
  assign hram_we    = clearing || s1_valid;
  assign hram_waddr = clearing ? clr_addr[HB-1:0] : s1_hsel;
  assign hram_wdata = clearing ? '0 : hist_new;
  assign cram_we    = clearing || s2_valid;
  assign lram_waddr = clearing ? clr_addr[LE-1:0] : s2_lidx;
  assign gram_waddr = clearing ? clr_addr[LE-1:0] : s2_gidx;
  assign cram_waddr = clearing ? clr_addr[LE-1:0] : s2_cidx;
  assign lram_wdata = clearing ? tbp_pkg::CTR_INIT : l_new;
  assign gram_wdata = clearing ? tbp_pkg::CTR_INIT : g_new;
  assign cram_wdata = clearing ? tbp_pkg::CTR_INIT : c_new;

  tbp_ram #(.ADDR_W(HB), .WIDTH(LE)) u_hist_ram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (hram_waddr),
    .wdata (hram_wdata),
    .raddr (in_hsel),
    .rdata (hram_q)
  );

  tbp_ram #(.ADDR_W(LE), .WIDTH(2)) u_local_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (lram_waddr),
    .wdata (lram_wdata),
    .raddr (hist_cur),
    .rdata (lram_q)
  );

  tbp_ram #(.ADDR_W(LE), .WIDTH(2)) u_gshare_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (gram_waddr),
    .wdata (gram_wdata),
    .raddr (s1_gidx),
    .rdata (gram_q)
  );

  tbp_ram #(.ADDR_W(LE), .WIDTH(2)) u_chooser_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (cram_waddr),
    .wdata (cram_wdata),
    .raddr (s1_cidx),
    .rdata (cram_q)
  );

  tbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (res),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_data    (out_res),
    .count     (fifo_count)
  );

  assign m_axis_tdata = {3'b000, out_res};

  a_credit: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(tbp_pkg::FIFO_DEPTH))
    else $error("result queue credit exceeded");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("transfer accepted during clearing pass");

  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid)
    else $error("pipeline lost an item");

  a_ghist_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(ghist))
    else $error("global history changed without a transfer");

endmodule

// ===== test/tournament_branch_predictor_core_tb.sv =====
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core_tb
// Self-checking bench for the tournament branch predictor. Branches go in on
// the input stream; a behavioural copy of the local, gshare and chooser tables
// predicts every result word, and each output transfer is checked field by
// field. Directed corner branches come first, then random phases with hot
// branch loops, all four modes, random stalls on both sides and a long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core_tb;

  localparam int TBL_BITS    = 10;
  localparam int TBL_SIZE    = 1 << TBL_BITS;
  localparam int HIST_COUNT  = 1 << tbp_pkg::HIST_BITS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 8;
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;

  logic [TBL_BITS-1:0] local_hist [HIST_COUNT];
  tbp_pkg::ctr_t       local_ctr [TBL_SIZE];
  tbp_pkg::ctr_t       global_ctr [TBL_SIZE];
  tbp_pkg::ctr_t       chooser_ctr [TBL_SIZE];
  logic [TBL_BITS-1:0] global_hist;
  logic [1:0]          pred_mode;

  tbp_pkg::result_t expected_results [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;
  bit rx_hold_req = 1'b0;

  tournament_branch_predictor_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic tbp_pkg::ctr_t counter_step(input tbp_pkg::ctr_t c, input logic up);
    if (up) begin
      return (c == 2'd3) ? c : c + 2'd1;
    end
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  task automatic predict_branch(input logic [31:0] addr, input logic dir);
    logic [tbp_pkg::HIST_BITS-1:0] hsel;
    logic [TBL_BITS-1:0]           lidx, gidx, cidx;
    logic                          lg, gg, use_g, tour, pred;
    tbp_pkg::ctr_t                 ch;
    tbp_pkg::result_t              res;
    hsel  = addr[tbp_pkg::HIST_BITS-1:0];
    lidx  = local_hist[hsel];
    gidx  = addr[TBL_BITS-1:0] ^ global_hist;
    cidx  = addr[TBL_BITS-1:0];
    lg    = local_ctr[lidx] >= 2'd2;
    gg    = global_ctr[gidx] >= 2'd2;
    ch    = chooser_ctr[cidx];
    use_g = ch >= 2'd2;
    tour  = use_g ? gg : lg;
    case (pred_mode)
      tbp_pkg::MODE_TAKEN:  pred = 1'b1;
      tbp_pkg::MODE_LOCAL:  pred = lg;
      tbp_pkg::MODE_GSHARE: pred = gg;
      default:              pred = tour;
    endcase
    if (tour == dir) begin
      if (ch == 2'd2) begin
        ch = 2'd3;
      end else if (ch == 2'd1) begin
        ch = 2'd0;
      end
    end else if (ch >= 2'd2) begin
      if (lg == dir) begin
        ch = ch - 2'd1;
      end
    end else if (gg == dir) begin
      ch = ch + 2'd1;
    end
    chooser_ctr[cidx] = ch;
    local_hist[hsel]  = {local_hist[hsel][TBL_BITS-2:0], dir};
    local_ctr[lidx]   = counter_step(local_ctr[lidx], dir);
    global_hist       = {global_hist[TBL_BITS-2:0], dir};
    global_ctr[gidx]  = counter_step(global_ctr[gidx], dir);
    res.predict_taken = pred;
    res.local_guess   = lg;
    res.global_guess  = gg;
    res.chose_global  = use_g;
    res.was_correct   = (pred == dir);
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got_v, exp_v);
    mismatch_count++;
  endtask

  // Receiver: random stalls, or a long hold-off on request.
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    tbp_pkg::result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = tbp_pkg::result_t'(m_axis_tdata[4:0]);
      if (m_axis_tdata[7:5] != 3'd0) begin
        report_mismatch("tdata padding", int'(m_axis_tdata[7:5]), 0);
      end
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", int'(m_axis_tdata), -1);
      end else begin
        want = expected_results.pop_front();
        if (got.predict_taken !== want.predict_taken) begin
          report_mismatch("predict_taken", int'(got.predict_taken),
                          int'(want.predict_taken));
        end
        if (got.local_guess !== want.local_guess) begin
          report_mismatch("local_guess", int'(got.local_guess),
                          int'(want.local_guess));
        end
        if (got.global_guess !== want.global_guess) begin
          report_mismatch("global_guess", int'(got.global_guess),
                          int'(want.global_guess));
        end
        if (got.chose_global !== want.chose_global) begin
          report_mismatch("chose_global", int'(got.chose_global),
                          int'(want.chose_global));
        end
        if (got.was_correct !== want.was_correct) begin
          report_mismatch("was_correct", int'(got.was_correct),
                          int'(want.was_correct));
        end
      end
    end
  end

  task automatic send_branch(input logic [31:0] addr, input logic dir);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, dir, addr};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    predict_branch(addr, dir);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pred_mode = m;
  endtask

  task automatic test_directed();
    logic [31:0] corner_addr [10];
    corner_addr = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_007F, 32'h0000_0080,
                    32'h0000_03FF, 32'h0000_0400, 32'h0000_FFFF, 32'hAAAA_AAAA,
                    32'h5555_5555, 32'h8000_0000};
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 10; i++) begin
      send_branch(corner_addr[i], i[0]);
    end
    // drive one branch's counters down so the components disagree
    repeat (3) send_branch(32'h0000_0015, 1'b0);
    write_mode(tbp_pkg::MODE_TAKEN);
    send_branch(32'h0000_0015, 1'b0);
    send_branch(32'h0000_0015, 1'b1);
    send_branch(32'hFFFF_FF80, 1'b0);
    send_branch(32'h0000_0015, 1'b0);
    write_mode(tbp_pkg::MODE_LOCAL);
    send_branch(32'h0000_0015, 1'b1);
    send_branch(32'h0000_0015, 1'b0);
    send_branch(32'h0000_0395, 1'b1);
    send_branch(32'h0000_0015, 1'b1);
    write_mode(tbp_pkg::MODE_GSHARE);
    send_branch(32'h0000_0015, 1'b0);
    send_branch(32'h0000_0015, 1'b1);
    send_branch(32'h0000_0015, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_random(input int n_items, input int tx_pct, input int rx_pct,
                             input logic [1:0] m);
    logic [31:0] hot_addr [8];
    int          hot_period [8];
    int          hot_count [8];
    logic [31:0] addr;
    logic        dir;
    int          r, k;
    logic [9:0]  low_bits;
    write_mode(m);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < 8; i++) begin
      hot_addr[i]   = $urandom;
      hot_period[i] = $urandom_range(6);
      hot_count[i]  = 0;
    end
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      if (r < 65) begin
        // loop-shaped branch: taken except once per period
        k = $urandom_range(7);
        hot_count[k]++;
        addr = hot_addr[k];
        dir  = (hot_period[k] == 0) ? 1'b1 : ((hot_count[k] % hot_period[k]) != 0);
      end else if (r < 85) begin
        addr = $urandom;
        dir  = 1'($urandom_range(1));
      end else begin
        case ($urandom_range(3))
          0:       low_bits = 10'h000;
          1:       low_bits = 10'h3FF;
          2:       low_bits = 10'h07F;
          default: low_bits = 10'h380;
        endcase
        addr = {22'($urandom_range(32'h003F_FFFF)), low_bits};
        dir  = 1'($urandom_range(1));
      end
      send_branch(addr, dir);
    end
  endtask

  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    for (int n = 0; n < 60; n++) begin
      send_branch($urandom, 1'($urandom_range(1)));
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < HIST_COUNT; i++) begin
      local_hist[i] = '0;
    end
    for (int i = 0; i < TBL_SIZE; i++) begin
      local_ctr[i]   = tbp_pkg::CTR_INIT;
      global_ctr[i]  = tbp_pkg::CTR_INIT;
      chooser_ctr[i] = tbp_pkg::CTR_INIT;
    end
    global_hist = '0;
    pred_mode   = tbp_pkg::MODE_TOURNEY;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(400, 7, 53, tbp_pkg::MODE_TOURNEY);
    test_random(300, 53, 7, tbp_pkg::MODE_LOCAL);
    test_random(300, 0, 0, tbp_pkg::MODE_GSHARE);
    test_random(250, 7, 53, tbp_pkg::MODE_TAKEN);
    test_output_stall();
    test_random(300, 0, 0, tbp_pkg::MODE_TOURNEY);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tbp_pkg.sv
hw/rtl/tbp_ram.sv
hw/rtl/tbp_out_fifo.sv
hw/rtl/tournament_branch_predictor_core.sv
test/tournament_branch_predictor_core_tb.sv
